/* design/qpds_pkg.sv */
// Package for the quadrature position servo: codes, register map and the decode table.
package qpds_pkg;

  localparam int DUTY_BITS_DEF      = 12;
  localparam int GAIN_FRAC_BITS_DEF = 8;

  localparam int GAIN_BITS  = 16;
  localparam int BAND_BITS  = 16;
  localparam int POS_BITS   = 32;
  localparam int ADDR_BITS  = 5;
  localparam int DATA_BITS  = 32;

  typedef enum logic [2:0] {
    OP_SAMPLE  = 3'd0,
    OP_TICK    = 3'd1,
    OP_MOVE    = 3'd2,
    OP_STOP    = 3'd3,
    OP_SET_POS = 3'd4,
    OP_RAW     = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_MOVE_OK    = 3'd1,
    EV_MOVE_REJ   = 3'd2,
    EV_ARRIVED    = 3'd3,
    EV_SOFT_LIMIT = 3'd4,
    EV_TOP_SWITCH = 3'd5,
    EV_DRIVING    = 3'd6
  } event_t;

  // What the last stage does with the stored drive value.
  typedef enum logic [1:0] {
    DRV_HOLD = 2'd0,
    DRV_ZERO = 2'd1,
    DRV_SET  = 2'd2,
    DRV_PD   = 2'd3
  } drv_act_t;

  typedef enum logic [2:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_DERIV_GAIN   = 3'd1,
    REG_ARRIVE_BAND  = 3'd2,
    REG_DUTY_FLOOR   = 3'd3,
    REG_DUTY_CEILING = 3'd4,
    REG_TRAVEL_LOW   = 3'd5,
    REG_TRAVEL_HIGH  = 3'd6
  } reg_idx_t;

  localparam logic [GAIN_BITS-1:0] PROP_GAIN_RST   = 16'd256;
  localparam logic [GAIN_BITS-1:0] DERIV_GAIN_RST  = 16'd0;
  localparam logic [BAND_BITS-1:0] ARRIVE_BAND_RST = 16'd4;
  localparam logic signed [POS_BITS-1:0] TRAVEL_LOW_RST  = 32'sd0;
  localparam logic signed [POS_BITS-1:0] TRAVEL_HIGH_RST = 32'sd100000;

  // 4x quadrature step, indexed by {previous phase, current phase}.
  // A transition where both channels flip at once counts as zero.
  function automatic logic signed [1:0] phase_step(input logic [3:0] idx);
    logic signed [1:0] s;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14:  s = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
      default:                  s = 2'sd0;
    endcase
    return s;
  endfunction

endpackage

/* design/qpds_ifs.sv */
// Request and result channel interfaces of the quadrature position servo.
interface qpds_cmd_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                opcode;
  logic                      chan_a;
  logic                      chan_b;
  logic                      top_switch;
  logic signed [31:0]        operand_value;

  modport source (output valid, opcode, chan_a, chan_b, top_switch, operand_value,
                  input ready);
  modport sink (input valid, opcode, chan_a, chan_b, top_switch, operand_value,
                output ready);
endinterface

interface qpds_res_if #(
  parameter int DUTY_BITS = qpds_pkg::DUTY_BITS_DEF
);
  logic                      valid;
  logic                      ready;
  logic                      bridge_in1;
  logic                      bridge_in2;
  logic [DUTY_BITS-1:0]      drive_duty;
  logic signed [31:0]        position_count;
  logic                      in_motion;
  logic [2:0]                event_code;

  modport source (output valid, bridge_in1, bridge_in2, drive_duty, position_count,
                  in_motion, event_code, input ready);
  modport sink (input valid, bridge_in1, bridge_in2, drive_duty, position_count,
                in_motion, event_code, output ready);
endinterface

/* design/quadrature_pd_position_servo.sv */
// Top level of the single-axis quadrature position servo with PD control.
//
// Usage: requests arrive on the cmd channel (valid/ready). Each request is an
// encoder sample, a control tick, a move, a stop, a position set or a raw drive.
// Every request yields exactly one result on the res channel, in order, with the
// H-bridge levels, the applied duty, the position count, the motion flag and an
// event code. Gains, arrival band, duty limits and travel limits are written over
// the APB port while the block is idle; reads return the register contents.
//
// Throughput is one request per clock while results are taken. Each request passes
// the input register, decode and state update, the two gain multipliers, the sum,
// then magnitude/limit and the result register. Position, target and motion state are
// updated in the decode stage, so back to back samples and ticks see each other's
// effects with no gap.
//
// Reset (synchronous, active high) clears the position, target, motion and drive
// state (drive zero means brake), loads the register defaults and empties the
// pipeline. When the receiver holds ready low with a result pending, the whole
// pipeline holds and cmd.ready drops until the result is taken.
module quadrature_pd_position_servo #(
  parameter int DUTY_BITS      = qpds_pkg::DUTY_BITS_DEF,
  parameter int GAIN_FRAC_BITS = qpds_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  qpds_cmd_if.sink                          cmd,
  qpds_res_if.source                        res,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [qpds_pkg::ADDR_BITS-1:0]    paddr,
  input  logic [qpds_pkg::DATA_BITS-1:0]    pwdata,
  output logic [qpds_pkg::DATA_BITS-1:0]    prdata,
  output logic                              pready
);
  import qpds_pkg::*;

  localparam int DW = DUTY_BITS;
  localparam int PW = GAIN_BITS + 1 + POS_BITS;      // prop product width
  localparam int DPW = GAIN_BITS + 1 + POS_BITS + 1; // deriv product width
  localparam int SW = DPW + 1;                       // sum width

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [GAIN_BITS-1:0]        prop_gain;
  logic [GAIN_BITS-1:0]        deriv_gain;
  logic [BAND_BITS-1:0]        arrive_band;
  logic [DW-1:0]               duty_floor;
  logic [DW-1:0]               duty_ceiling;
  logic signed [POS_BITS-1:0]  travel_low;
  logic signed [POS_BITS-1:0]  travel_high;
  logic                        cfg_wr;
  reg_idx_t                    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain    <= PROP_GAIN_RST;
      deriv_gain   <= DERIV_GAIN_RST;
      arrive_band  <= ARRIVE_BAND_RST;
      duty_floor   <= '0;
      duty_ceiling <= '1;
      travel_low   <= TRAVEL_LOW_RST;
      travel_high  <= TRAVEL_HIGH_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PROP_GAIN:    prop_gain    <= pwdata[GAIN_BITS-1:0];
        REG_DERIV_GAIN:   deriv_gain   <= pwdata[GAIN_BITS-1:0];
        REG_ARRIVE_BAND:  arrive_band  <= pwdata[BAND_BITS-1:0];
        REG_DUTY_FLOOR:   duty_floor   <= pwdata[DW-1:0];
        REG_DUTY_CEILING: duty_ceiling <= pwdata[DW-1:0];
        REG_TRAVEL_LOW:   travel_low   <= $signed(pwdata[POS_BITS-1:0]);
        REG_TRAVEL_HIGH:  travel_high  <= $signed(pwdata[POS_BITS-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PROP_GAIN:    prdata = DATA_BITS'(prop_gain);
      REG_DERIV_GAIN:   prdata = DATA_BITS'(deriv_gain);
      REG_ARRIVE_BAND:  prdata = DATA_BITS'(arrive_band);
      REG_DUTY_FLOOR:   prdata = DATA_BITS'(duty_floor);
      REG_DUTY_CEILING: prdata = DATA_BITS'(duty_ceiling);
      REG_TRAVEL_LOW:   prdata = travel_low;
      REG_TRAVEL_HIGH:  prdata = travel_high;
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: every stage moves together whenever the result register
  // is free or being emptied this cycle.
  // ---------------------------------------------------------------------------
  logic out_valid;
  logic adv;

  assign adv       = !out_valid || res.ready;
  assign cmd.ready = adv;

  // Stage 1: input register.
  logic                       s1_valid;
  logic [2:0]                 s1_opcode;
  logic                       s1_a;
  logic                       s1_b;
  logic                       s1_top;
  logic signed [POS_BITS-1:0] s1_operand;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_opcode  <= cmd.opcode;
      s1_a       <= cmd.chan_a;
      s1_b       <= cmd.chan_b;
      s1_top     <= cmd.top_switch;
      s1_operand <= cmd.operand_value;
    end
  end

  // ---------------------------------------------------------------------------
  // Decode and servo state
  // ---------------------------------------------------------------------------
  logic signed [POS_BITS-1:0] position, position_next;
  logic [1:0]                 last_phase, last_phase_next;
  logic signed [POS_BITS-1:0] target, target_next;
  logic                       moving_flag, moving_flag_next;
  logic signed [POS_BITS-1:0] previous_error, previous_error_next;

  logic signed [POS_BITS:0]   err_wide;
  logic signed [POS_BITS-1:0] err_sat;
  logic [POS_BITS-1:0]        err_abs;
  logic signed [POS_BITS:0]   deriv;
  logic [1:0]                 phase;
  logic signed [1:0]          step;
  logic signed [POS_BITS:0]   op_wide;
  logic signed [POS_BITS:0]   ceil_wide;
  event_t                     ev_d;
  drv_act_t                   act_d;
  logic signed [DW:0]         raw_d;

  assign phase    = {s1_a, s1_b};
  assign step     = phase_step({last_phase, phase});
  // Error is formed one bit wider, then saturated to the count range.
  assign err_wide = {target[POS_BITS-1], target} - {position[POS_BITS-1], position};
  assign err_sat  = (err_wide[POS_BITS:POS_BITS-1] == 2'b01) ? {1'b0, {(POS_BITS-1){1'b1}}} :
                    (err_wide[POS_BITS:POS_BITS-1] == 2'b10) ? {1'b1, {(POS_BITS-1){1'b0}}} :
                    err_wide[POS_BITS-1:0];
  assign err_abs  = err_sat[POS_BITS-1] ? POS_BITS'(-err_sat) : POS_BITS'(err_sat);
  assign deriv    = {err_sat[POS_BITS-1], err_sat} -
                    {previous_error[POS_BITS-1], previous_error};
  assign op_wide  = {s1_operand[POS_BITS-1], s1_operand};
  assign ceil_wide = $signed({{(POS_BITS+1-DW){1'b0}}, duty_ceiling});

  always_comb begin
    position_next       = position;
    last_phase_next     = last_phase;
    target_next         = target;
    moving_flag_next    = moving_flag;
    previous_error_next = previous_error;
    ev_d                = EV_NONE;
    act_d               = DRV_HOLD;
    raw_d               = '0;
    case (op_t'(s1_opcode))
      OP_SAMPLE: begin
        position_next   = position + {{(POS_BITS-2){step[1]}}, step};
        last_phase_next = phase;
      end
      OP_TICK: begin
        if (moving_flag) begin
          previous_error_next = err_sat;
          if (err_sat > 0 && s1_top) begin
            // Top switch while moving up: pin the count at the top of travel.
            act_d            = DRV_ZERO;
            position_next    = travel_high;
            target_next      = travel_high;
            moving_flag_next = 1'b0;
            ev_d             = EV_TOP_SWITCH;
          end else if ((position <= travel_low && err_sat < 0) ||
                       (position >= travel_high && err_sat > 0)) begin
            act_d            = DRV_ZERO;
            moving_flag_next = 1'b0;
            ev_d             = EV_SOFT_LIMIT;
          end else if (err_abs <= POS_BITS'(arrive_band)) begin
            act_d            = DRV_ZERO;
            moving_flag_next = 1'b0;
            ev_d             = EV_ARRIVED;
          end else begin
            act_d = DRV_PD;
            ev_d  = EV_DRIVING;
          end
        end
      end
      OP_MOVE: begin
        if (s1_operand < travel_low || s1_operand > travel_high) begin
          ev_d = EV_MOVE_REJ;
        end else begin
          target_next         = s1_operand;
          previous_error_next = '0;
          moving_flag_next    = 1'b1;
          ev_d                = EV_MOVE_OK;
        end
      end
      OP_STOP: begin
        act_d            = DRV_ZERO;
        moving_flag_next = 1'b0;
      end
      OP_SET_POS: begin
        position_next    = s1_operand;
        target_next      = s1_operand;
        moving_flag_next = 1'b0;
      end
      OP_RAW: begin
        moving_flag_next = 1'b0;
        act_d            = DRV_SET;
        if (op_wide > ceil_wide) begin
          raw_d = $signed({1'b0, duty_ceiling});
        end else if (op_wide < -ceil_wide) begin
          raw_d = -$signed({1'b0, duty_ceiling});
        end else begin
          raw_d = s1_operand[DW:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position       <= '0;
      last_phase     <= '0;
      target         <= '0;
      moving_flag    <= 1'b0;
      previous_error <= '0;
    end else if (adv && s1_valid) begin
      position       <= position_next;
      last_phase     <= last_phase_next;
      target         <= target_next;
      moving_flag    <= moving_flag_next;
      previous_error <= previous_error_next;
    end
  end

  // Stage 2: decoded request, with the state as it stands after it.
  logic                       s2_valid;
  logic signed [POS_BITS-1:0] s2_err;
  logic signed [POS_BITS:0]   s2_deriv;
  drv_act_t                   s2_act;
  logic signed [DW:0]         s2_raw;
  logic signed [POS_BITS-1:0] s2_pos;
  logic                       s2_mov;
  event_t                     s2_ev;

  // Stage 3: gain products.
  logic                       s3_valid;
  logic signed [PW-1:0]       s3_prod_p;
  logic signed [DPW-1:0]      s3_prod_d;
  drv_act_t                   s3_act;
  logic signed [DW:0]         s3_raw;
  logic signed [POS_BITS-1:0] s3_pos;
  logic                       s3_mov;
  event_t                     s3_ev;

  // Stage 4: PD sum in Q(GAIN_FRAC_BITS).
  logic                       s4_valid;
  logic signed [SW-1:0]       s4_sum;
  drv_act_t                   s4_act;
  logic signed [DW:0]         s4_raw;
  logic signed [POS_BITS-1:0] s4_pos;
  logic                       s4_mov;
  event_t                     s4_ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_err    <= err_sat;
      s2_deriv  <= deriv;
      s2_act    <= act_d;
      s2_raw    <= raw_d;
      s2_pos    <= position_next;
      s2_mov    <= moving_flag_next;
      s2_ev     <= ev_d;

      s3_prod_p <= $signed({1'b0, prop_gain}) * s2_err;
      s3_prod_d <= $signed({1'b0, deriv_gain}) * s2_deriv;
      s3_act    <= s2_act;
      s3_raw    <= s2_raw;
      s3_pos    <= s2_pos;
      s3_mov    <= s2_mov;
      s3_ev     <= s2_ev;

      s4_sum    <= {{(SW-PW){s3_prod_p[PW-1]}}, s3_prod_p} +
                   {{(SW-DPW){s3_prod_d[DPW-1]}}, s3_prod_d};
      s4_act    <= s3_act;
      s4_raw    <= s3_raw;
      s4_pos    <= s3_pos;
      s4_mov    <= s3_mov;
      s4_ev     <= s3_ev;
    end
  end

  // ---------------------------------------------------------------------------
  // Last stage: magnitude, floor and ceiling, drive state and result register
  // ---------------------------------------------------------------------------
  logic signed [DW:0]  drive_value;
  logic [SW-1:0]       sum_abs;
  logic [SW-1:0]       sum_mag;
  logic [SW-1:0]       floor_ext;
  logic [SW-1:0]       ceil_ext;
  logic [SW-1:0]       lifted;
  logic [DW-1:0]       pd_mag;
  logic signed [DW:0]  pd_drive;
  logic signed [DW:0]  drive_new;
  logic signed [DW:0]  drive_neg;

  assign sum_abs   = s4_sum[SW-1] ? SW'(-s4_sum) : SW'(s4_sum);
  assign sum_mag   = sum_abs >> GAIN_FRAC_BITS;
  assign floor_ext = SW'(duty_floor);
  assign ceil_ext  = SW'(duty_ceiling);
  // Raise to the floor first, then cap; a floor above the ceiling loses.
  assign lifted    = (sum_mag < floor_ext) ? floor_ext : sum_mag;
  assign pd_mag    = (lifted > ceil_ext) ? duty_ceiling : lifted[DW-1:0];
  assign pd_drive  = s4_sum[SW-1] ? -$signed({1'b0, pd_mag}) : $signed({1'b0, pd_mag});

  always_comb begin
    case (s4_act)
      DRV_HOLD: drive_new = drive_value;
      DRV_ZERO: drive_new = '0;
      DRV_SET:  drive_new = s4_raw;
      DRV_PD:   drive_new = pd_drive;
      default:  drive_new = drive_value;
    endcase
  end

  assign drive_neg = -drive_new;

  logic                       out_in1;
  logic                       out_in2;
  logic [DW-1:0]              out_duty;
  logic signed [POS_BITS-1:0] out_pos;
  logic                       out_mov;
  event_t                     out_ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      drive_value <= '0;
    end else if (adv) begin
      out_valid <= s4_valid;
      if (s4_valid) begin
        drive_value <= drive_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s4_valid) begin
      out_in1  <= !drive_new[DW];
      out_in2  <= drive_new[DW] || (drive_new == '0);
      out_duty <= drive_new[DW] ? drive_neg[DW-1:0] : drive_new[DW-1:0];
      out_pos  <= s4_pos;
      out_mov  <= s4_mov;
      out_ev   <= s4_ev;
    end
  end

  assign res.valid          = out_valid;
  assign res.bridge_in1     = out_in1;
  assign res.bridge_in2     = out_in2;
  assign res.drive_duty     = out_duty;
  assign res.position_count = out_pos;
  assign res.in_motion      = out_mov;
  assign res.event_code     = out_ev;

endmodule

/* tb/tb_quadrature_pd_position_servo.sv */
// Self-checking testbench for the quadrature PD position servo.
module tb_quadrature_pd_position_servo;
  import qpds_pkg::*;

  // Opcodes that the servo does not decode; they must change nothing.
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;

  // The run is cut off here; a correct run needs a small fraction of it.
  localparam int CYCLE_LIMIT     = 400000;
  localparam int ITEMS_PER_PHASE = 185;
  localparam int PHASES          = 10;
  localparam int LONG_HOLD       = 100;

  // 4x decode, indexed by {previous A B, current A B}. Double-bit changes count zero.
  localparam int QUAD_STEP [16] = '{ 0, -1,  1,  0,
                                     1,  0,  0, -1,
                                    -1,  0,  0,  1,
                                     0,  1, -1,  0};
  // Gray order of a forward (count up) and a backward walk through the phases.
  localparam logic [1:0] WALK_UP [4]   = '{2'd2, 2'd0, 2'd3, 2'd1};
  localparam logic [1:0] WALK_DOWN [4] = '{2'd1, 2'd3, 2'd0, 2'd2};

  typedef struct packed {
    logic [2:0]         opcode;
    logic               chan_a;
    logic               chan_b;
    logic               top_switch;
    logic signed [31:0] operand_value;
  } servo_req_t;

  typedef struct packed {
    logic                     bridge_in1;
    logic                     bridge_in2;
    logic [DUTY_BITS_DEF-1:0] drive_duty;
    logic signed [31:0]       position_count;
    logic                     in_motion;
    event_t                   event_code;
  } servo_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // APB side. pready and prdata come back from the block.
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  qpds_cmd_if cmd_ch ();
  qpds_res_if res_ch ();

  quadrature_pd_position_servo dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  // Mirror of the register file, kept in step with every APB write.
  logic [15:0]              cfg_prop;
  logic [15:0]              cfg_deriv;
  logic [15:0]              cfg_band;
  logic [DUTY_BITS_DEF-1:0] cfg_floor;
  logic [DUTY_BITS_DEF-1:0] cfg_ceiling;
  logic signed [31:0]       cfg_low;
  logic signed [31:0]       cfg_high;

  // Predicted axis state. The drive is signed; its magnitude is capped at the ceiling when set.
  logic signed [31:0] axis_pos;
  logic signed [31:0] axis_target;
  logic signed [31:0] axis_prev_err;
  logic               axis_moving;
  logic [1:0]         enc_phase;
  int                 axis_drive;

  // Requests waiting to be offered, and servo outputs predicted but not yet seen.
  servo_req_t cmd_backlog[$];
  servo_res_t predicted_outputs[$];
  servo_req_t on_bus;
  logic       offering = 1'b0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int results_seen = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;
  int cycle_count = 0;

  // Stimulus-side memory of the last encoder phase sent and the walk direction.
  logic [1:0] walk_phase = 2'd0;
  logic       walk_up = 1'b1;

  // Advances the predicted axis by one request and returns the outputs it should show.
  function automatic servo_res_t advance_axis(input servo_req_t rq);
    servo_res_t         o;
    event_t             ev;
    logic [1:0]         ph;
    longint             err_w;
    longint             deriv;
    longint             pd_out;
    longint             mag;
    logic signed [31:0] err;
    int                 duty_abs;
    ev = EV_NONE;
    case (rq.opcode)
      OP_SAMPLE: begin
        ph = {rq.chan_a, rq.chan_b};
        axis_pos = axis_pos + QUAD_STEP[{enc_phase, ph}];
        enc_phase = ph;
      end
      OP_TICK: begin
        if (axis_moving) begin
          err_w = longint'(axis_target) - longint'(axis_pos);
          if (err_w > I32_MAX) err_w = I32_MAX;
          if (err_w < I32_MIN) err_w = I32_MIN;
          err = err_w[31:0];
          deriv = longint'(err) - longint'(axis_prev_err);
          axis_prev_err = err;
          if (err > 0 && rq.top_switch) begin
            // Hitting the top switch on the way up pins the axis at the top.
            axis_drive = 0;
            axis_pos = cfg_high;
            axis_target = cfg_high;
            axis_moving = 1'b0;
            ev = EV_TOP_SWITCH;
          end else if ((axis_pos <= cfg_low && err < 0) ||
                       (axis_pos >= cfg_high && err > 0)) begin
            axis_drive = 0;
            axis_moving = 1'b0;
            ev = EV_SOFT_LIMIT;
          end else if ((err < 0 ? -longint'(err) : longint'(err)) <= longint'(cfg_band)) begin
            axis_drive = 0;
            axis_moving = 1'b0;
            ev = EV_ARRIVED;
          end else begin
            pd_out = longint'(cfg_prop) * longint'(err) + longint'(cfg_deriv) * deriv;
            mag = (pd_out < 0 ? -pd_out : pd_out) >> GAIN_FRAC_BITS_DEF;
            // The floor is applied first so that the ceiling wins when they cross.
            if (mag < longint'(cfg_floor)) mag = longint'(cfg_floor);
            if (mag > longint'(cfg_ceiling)) mag = longint'(cfg_ceiling);
            axis_drive = (pd_out < 0) ? -mag : mag;
            ev = EV_DRIVING;
          end
        end
      end
      OP_MOVE: begin
        if (rq.operand_value < cfg_low || rq.operand_value > cfg_high) begin
          ev = EV_MOVE_REJ;
        end else begin
          axis_target = rq.operand_value;
          axis_prev_err = 0;
          axis_moving = 1'b1;
          ev = EV_MOVE_OK;
        end
      end
      OP_STOP: begin
        axis_drive = 0;
        axis_moving = 1'b0;
      end
      OP_SET_POS: begin
        axis_pos = rq.operand_value;
        axis_target = rq.operand_value;
        axis_moving = 1'b0;
      end
      OP_RAW: begin
        axis_moving = 1'b0;
        if (longint'(rq.operand_value) > longint'(cfg_ceiling))
          axis_drive = int'(cfg_ceiling);
        else if (longint'(rq.operand_value) < -longint'(cfg_ceiling))
          axis_drive = -int'(cfg_ceiling);
        else
          axis_drive = rq.operand_value;
      end
      default: ;
    endcase
    duty_abs = (axis_drive < 0) ? -axis_drive : axis_drive;
    o.bridge_in1 = (axis_drive >= 0);
    o.bridge_in2 = (axis_drive <= 0);
    o.drive_duty = duty_abs[DUTY_BITS_DEF-1:0];
    o.position_count = axis_pos;
    o.in_motion = axis_moving;
    o.event_code = ev;
    return o;
  endfunction

  // Request driver: offers the backlog at the chosen idle rate and predicts
  // the outputs of every request at the edge where it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        predicted_outputs.push_back(advance_axis(on_bus));
        offering = 1'b0;
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = cmd_backlog.pop_front();
          offering = 1'b1;
          cmd_ch.valid <= 1'b1;
          cmd_ch.opcode <= on_bus.opcode;
          cmd_ch.chan_a <= on_bus.chan_a;
          cmd_ch.chan_b <= on_bus.chan_b;
          cmd_ch.top_switch <= on_bus.top_switch;
          cmd_ch.operand_value <= on_bus.operand_value;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      mismatches++;
    end
  endtask

  // Result monitor: checks each accepted result against the oldest prediction
  // and decides ready for the next cycle. Once, early in the run, it holds
  // ready low for a long stretch so that the pipeline fills and cmd.ready drops.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (predicted_outputs.size() == 0) begin
          $error("result arrived with no request outstanding");
          mismatches++;
        end else begin
          servo_res_t want;
          want = predicted_outputs.pop_front();
          compare_field("bridge_in1", want.bridge_in1, res_ch.bridge_in1);
          compare_field("bridge_in2", want.bridge_in2, res_ch.bridge_in2);
          compare_field("drive_duty", want.drive_duty, res_ch.drive_duty);
          compare_field("position_count", want.position_count, res_ch.position_count);
          compare_field("in_motion", want.in_motion, res_ch.in_motion);
          compare_field("event_code", want.event_code, res_ch.event_code);
        end
        results_seen++;
      end
      if (!long_hold_done && results_seen >= 150) begin
        hold_left = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // One APB write: setup cycle, then an access cycle held until pready.
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PROP_GAIN:    cfg_prop = val[15:0];
      REG_DERIV_GAIN:   cfg_deriv = val[15:0];
      REG_ARRIVE_BAND:  cfg_band = val[15:0];
      REG_DUTY_FLOOR:   cfg_floor = val[DUTY_BITS_DEF-1:0];
      REG_DUTY_CEILING: cfg_ceiling = val[DUTY_BITS_DEF-1:0];
      REG_TRAVEL_LOW:   cfg_low = val;
      REG_TRAVEL_HIGH:  cfg_high = val;
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [15:0] prop, input logic [15:0] deriv,
                               input logic [15:0] band, input logic [11:0] floor_d,
                               input logic [11:0] ceil_d, input logic signed [31:0] low,
                               input logic signed [31:0] high);
    write_reg(REG_PROP_GAIN, prop);
    write_reg(REG_DERIV_GAIN, deriv);
    write_reg(REG_ARRIVE_BAND, band);
    write_reg(REG_DUTY_FLOOR, floor_d);
    write_reg(REG_DUTY_CEILING, ceil_d);
    write_reg(REG_TRAVEL_LOW, low);
    write_reg(REG_TRAVEL_HIGH, high);
  endtask

  // Waits until nothing is queued, offered or outstanding, so the block is idle.
  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || offering || predicted_outputs.size() != 0)
      @(posedge clk);
  endtask

  task automatic push_req(input logic [2:0] op, input logic a, input logic b,
                          input logic top, input logic signed [31:0] val);
    servo_req_t rq;
    rq.opcode = op;
    rq.chan_a = a;
    rq.chan_b = b;
    rq.top_switch = top;
    rq.operand_value = val;
    cmd_backlog.push_back(rq);
  endtask

  function automatic longint rand_between(input longint lo, input longint hi);
    longint unsigned span;
    if (hi <= lo) return lo;
    span = hi - lo + 1;
    return lo + longint'({$urandom, $urandom} % span);
  endfunction

  function automatic logic signed [31:0] to_i32(input longint v);
    if (v > I32_MAX) v = I32_MAX;
    if (v < I32_MIN) v = I32_MIN;
    return v[31:0];
  endfunction

  // Encoder sample that mostly continues the walk; now and then a random level
  // pair, which may be a double-bit change.
  task automatic push_walk_sample();
    logic [1:0] ph;
    if ($urandom_range(19) == 0) ph = 2'($urandom_range(3));
    else ph = walk_up ? WALK_UP[walk_phase] : WALK_DOWN[walk_phase];
    walk_phase = ph;
    push_req(OP_SAMPLE, ph[1], ph[0], 1'($urandom), $urandom);
  endtask

  // A mostly valid move: place the axis near the travel window, usually move inside it,
  // then let the encoder walk toward the goal between control ticks.
  task automatic push_move_episode(output int made);
    longint lo, hi, start, goal;
    int     steps;
    lo = (cfg_low < cfg_high) ? cfg_low : cfg_high;
    hi = (cfg_low < cfg_high) ? cfg_high : cfg_low;
    start = rand_between(longint'(to_i32(lo - 20)), longint'(to_i32(hi + 20)));
    if (cfg_low <= cfg_high && $urandom_range(9) != 0) goal = rand_between(cfg_low, cfg_high);
    else goal = longint'($signed(32'($urandom)));
    push_req(OP_SET_POS, 1'($urandom), 1'($urandom), 1'($urandom), to_i32(start));
    push_req(OP_MOVE, 1'($urandom), 1'($urandom), 1'($urandom), to_i32(goal));
    walk_up = (goal > start);
    steps = $urandom_range(4, 24);
    for (int k = 0; k < steps; k++) begin
      if ($urandom_range(19) == 0) walk_up = !walk_up;
      if ($urandom_range(9) < 6) push_walk_sample();
      else push_req(OP_TICK, 1'($urandom), 1'($urandom), ($urandom_range(12) == 0), $urandom);
    end
    made = steps + 2;
  endtask

  // A lone request of any kind, including the undecoded opcodes and full-range operands.
  task automatic push_noise_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 25) begin
      push_walk_sample();
    end else if (pick < 45) begin
      push_req(OP_TICK, 1'($urandom), 1'($urandom), 1'($urandom), $urandom);
    end else if (pick < 57) begin
      push_req(OP_MOVE, 1'($urandom), 1'($urandom), 1'($urandom), $urandom);
    end else if (pick < 65) begin
      push_req(OP_STOP, 1'($urandom), 1'($urandom), 1'($urandom), $urandom);
    end else if (pick < 73) begin
      push_req(OP_SET_POS, 1'($urandom), 1'($urandom), 1'($urandom), $urandom);
    end else if (pick < 92) begin
      if ($urandom_range(1) == 0)
        push_req(OP_RAW, 1'($urandom), 1'($urandom), 1'($urandom),
                 to_i32(rand_between(-5000, 5000)));
      else
        push_req(OP_RAW, 1'($urandom), 1'($urandom), 1'($urandom), $urandom);
    end else begin
      push_req(($urandom_range(1) == 0) ? OP_SPARE_6 : OP_SPARE_7,
               1'($urandom), 1'($urandom), 1'($urandom), $urandom);
    end
  endtask

  // Register settings for one random phase. Narrow travel windows make soft
  // limits and arrivals common; some phases cross the duty floor over the ceiling.
  task automatic load_random_settings();
    logic [15:0]        prop, deriv, band;
    logic [11:0]        floor_d, ceil_d;
    logic signed [31:0] low, high;
    int                 pick;
    prop = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(1024));
    deriv = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(512));
    band = ($urandom_range(5) == 0) ? 16'($urandom) : 16'($urandom_range(8));
    floor_d = 12'($urandom_range(300));
    ceil_d = 12'($urandom_range(100, 4095));
    if ($urandom_range(4) == 0) begin
      floor_d = 12'($urandom_range(2000, 4095));
      ceil_d = 12'($urandom_range(1999));
    end
    pick = $urandom_range(99);
    if (pick < 60) begin
      low = -$urandom_range(60);
      high = $urandom_range(60);
    end else if (pick < 85) begin
      low = -$urandom_range(100000);
      high = $urandom_range(100000);
    end else begin
      low = $urandom;
      high = $urandom;
    end
    load_settings(prop, deriv, band, floor_d, ceil_d, low, high);
  endtask

  initial begin
    int made;
    int n;
    cmd_ch.valid = 1'b0;
    cmd_ch.opcode = OP_SAMPLE;
    cmd_ch.chan_a = 1'b0;
    cmd_ch.chan_b = 1'b0;
    cmd_ch.top_switch = 1'b0;
    cmd_ch.operand_value = '0;
    res_ch.ready = 1'b0;

    // Predictor starts from the reset state of the block.
    cfg_prop = PROP_GAIN_RST;
    cfg_deriv = DERIV_GAIN_RST;
    cfg_band = ARRIVE_BAND_RST;
    cfg_floor = '0;
    cfg_ceiling = '1;
    cfg_low = TRAVEL_LOW_RST;
    cfg_high = TRAVEL_HIGH_RST;
    axis_pos = '0;
    axis_target = '0;
    axis_prev_err = '0;
    axis_moving = 1'b0;
    enc_phase = 2'd0;
    axis_drive = 0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset settings, with no idling on either side.
    // A full backward walk, then double-bit changes that must count zero and a forward step.
    push_req(OP_SAMPLE, 1'b0, 1'b0, 1'b0, 0);
    push_req(OP_SAMPLE, 1'b0, 1'b1, 1'b0, 0);
    push_req(OP_SAMPLE, 1'b1, 1'b1, 1'b0, 0);
    push_req(OP_SAMPLE, 1'b1, 1'b0, 1'b0, 0);
    push_req(OP_SAMPLE, 1'b0, 1'b0, 1'b0, 0);
    push_req(OP_SAMPLE, 1'b1, 1'b1, 1'b0, 0);
    push_req(OP_SAMPLE, 1'b0, 1'b0, 1'b0, 0);
    push_req(OP_SAMPLE, 1'b1, 1'b0, 1'b0, 0);
    // A tick while idle reports nothing; moves outside the window are rejected.
    push_req(OP_TICK, 1'b0, 1'b0, 1'b1, 0);
    push_req(OP_MOVE, 1'b0, 1'b0, 1'b0, -5);
    push_req(OP_MOVE, 1'b0, 1'b0, 1'b0, 100001);
    push_req(OP_MOVE, 1'b0, 1'b0, 1'b0, 32'h8000_0000);
    push_req(OP_MOVE, 1'b0, 1'b0, 1'b0, 32'h7fff_ffff);
    // Arrival inside the band, then driving, then the top switch on the way up.
    push_req(OP_SET_POS, 1'b0, 1'b0, 1'b0, 0);
    push_req(OP_MOVE, 1'b0, 1'b0, 1'b0, 3);
    push_req(OP_TICK, 1'b0, 1'b0, 1'b0, 0);
    push_req(OP_MOVE, 1'b0, 1'b0, 1'b0, 1000);
    push_req(OP_TICK, 1'b0, 1'b0, 1'b0, 0);
    push_req(OP_TICK, 1'b0, 1'b0, 1'b1, 0);
    // Negative drive toward a lower target, then stop.
    push_req(OP_SET_POS, 1'b0, 1'b0, 1'b0, 500);
    push_req(OP_MOVE, 1'b0, 1'b0, 1'b0, 10);
    push_req(OP_TICK, 1'b0, 1'b0, 1'b0, 0);
    push_req(OP_STOP, 1'b0, 1'b0, 1'b0, 0);
    // Raw drive is clipped at the ceiling in both directions; zero is brake.
    push_req(OP_RAW, 1'b0, 1'b0, 1'b0, 5000);
    push_req(OP_RAW, 1'b0, 1'b0, 1'b0, -5000);
    push_req(OP_RAW, 1'b0, 1'b0, 1'b0, 0);
    push_req(OP_RAW, 1'b0, 1'b0, 1'b0, 7);
    push_req(OP_SPARE_6, 1'b1, 1'b1, 1'b1, 32'hffff_ffff);
    push_req(OP_SPARE_7, 1'b0, 1'b1, 1'b0, 32'h5555_aaaa);
    // The position count wraps both ways around the 32-bit limits.
    push_req(OP_SET_POS, 1'b0, 1'b0, 1'b0, 32'h7fff_ffff);
    push_req(OP_SAMPLE, 1'b1, 1'b1, 1'b0, 0);
    push_req(OP_SAMPLE, 1'b1, 1'b0, 1'b0, 0);
    walk_phase = 2'd2;
    // Start a move, then pull the top of the window down to the axis.
    push_req(OP_SET_POS, 1'b0, 1'b0, 1'b0, 0);
    push_req(OP_MOVE, 1'b0, 1'b0, 1'b0, 500);
    wait_idle();
    write_reg(REG_TRAVEL_HIGH, 0);
    push_req(OP_TICK, 1'b0, 1'b0, 1'b0, 0);
    wait_idle();
    // Same at the bottom: a move downward with the floor of the window raised above it.
    write_reg(REG_TRAVEL_HIGH, 100000);
    push_req(OP_SET_POS, 1'b0, 1'b0, 1'b0, 10);
    push_req(OP_MOVE, 1'b0, 1'b0, 1'b0, 0);
    wait_idle();
    write_reg(REG_TRAVEL_LOW, 20);
    push_req(OP_TICK, 1'b0, 1'b0, 1'b0, 0);
    wait_idle();

    // Random phases. Each one starts idle, loads all registers, and cycles the
    // idling pattern: none, sender idle, receiver stalling, then both.
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      if (p == 1) begin
        // Widest window and largest gains: the error saturates and the drive pins high.
        load_settings(16'hffff, 16'hffff, 16'h0000, 12'h000, 12'hfff,
                      32'h8000_0000, 32'h7fff_ffff);
        push_req(OP_SET_POS, 1'b0, 1'b0, 1'b0, 32'h8000_0000);
        push_req(OP_MOVE, 1'b0, 1'b0, 1'b0, 32'h7fff_ffff);
        push_req(OP_TICK, 1'b0, 1'b0, 1'b0, 0);
        push_req(OP_SAMPLE, 1'b1, 1'b0, 1'b0, 0);
        push_req(OP_TICK, 1'b0, 1'b0, 1'b0, 0);
        push_req(OP_SET_POS, 1'b0, 1'b0, 1'b0, 32'h7fff_ffff);
        push_req(OP_MOVE, 1'b0, 1'b0, 1'b0, 32'h8000_0000);
        push_req(OP_TICK, 1'b0, 1'b0, 1'b0, 0);
        push_req(OP_MOVE, 1'b0, 1'b0, 1'b0, 32'h7fff_ffff);
        push_req(OP_TICK, 1'b0, 1'b0, 1'b0, 0);
        walk_phase = 2'd2;
      end else if (p == 2) begin
        // Inverted window rejects every move; the floor sits above a zero ceiling.
        load_settings(16'h0000, 16'h0000, 16'hffff, 12'hfff, 12'h000,
                      32'h7fff_ffff, 32'h8000_0000);
      end else begin
        load_random_settings();
      end
      made = 0;
      while (made < ITEMS_PER_PHASE) begin
        if ($urandom_range(99) < 65) begin
          push_move_episode(n);
          made += n;
        end else begin
          push_noise_item();
          made++;
        end
      end
      wait_idle();
    end

    // Let the pipeline run dry so a stray extra result would still be seen.
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
